>>> sv/sv39ptm_pkg.sv
// Package for the Sv39 page table mapper: field widths, constants,
// status and operation codes and the structs shared between modules.
// No dependencies.
`default_nettype none

package sv39ptm_pkg;

   localparam int PPN_W             = 44;
   localparam int VPN_W             = 27;
   localparam int ENTRY_W           = 64;
   localparam int COUNT_W           = 7;
   localparam int PERM_W            = 8;
   localparam int LOC_W             = 15;
   localparam int USE_W             = 7;
   localparam int STATUS_W          = 2;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int SLOT_W            = $clog2(ENTRIES_PER_TABLE);
   localparam int MAX_RANGE_PAGES   = 64;
   localparam int POOL_PAGES_DEF    = 64;
   localparam int PPN_LSB           = 10;

   localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

   localparam logic [STATUS_W-1:0] ST_MAPPED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic             op;
      logic [PPN_W-1:0] a;
      logic [PPN_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [PPN_W-1:0] sum;
      logic             beyond_pool;
   } alu_rsp_type;

endpackage

`default_nettype wire

>>> sv/sv39ptm_alu.sv
// Shared 44-bit add/subtract unit with a compare against the pool size.
// Depends on sv39ptm_pkg.
`default_nettype none

module sv39ptm_alu #(
   parameter int POOL_PAGES = sv39ptm_pkg::POOL_PAGES_DEF
) (
   input  sv39ptm_pkg::alu_req_type alu_req,
   output sv39ptm_pkg::alu_rsp_type alu_rsp
);

   logic [sv39ptm_pkg::PPN_W-1:0] sum;

   always_comb begin
      if (alu_req.op == sv39ptm_pkg::ALU_SUB) begin
         sum = alu_req.a - alu_req.b;
      end else begin
         sum = alu_req.a + alu_req.b;
      end
   end

   assign alu_rsp.sum         = sum;
   assign alu_rsp.beyond_pool = (sum >= sv39ptm_pkg::PPN_W'(POOL_PAGES));

endmodule

`default_nettype wire

>>> sv/sv39ptm_table.sv
// Table store of the pool pages: one write and one registered read port,
// with a clearing pass that zeroes every entry after reset. Depends on sv39ptm_pkg.
`default_nettype none

module sv39ptm_table #(
   parameter int POOL_PAGES = sv39ptm_pkg::POOL_PAGES_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               wr_en,
   input  wire [$clog2(POOL_PAGES)+sv39ptm_pkg::SLOT_W-1:0] addr,
   input  wire [sv39ptm_pkg::ENTRY_W-1:0]    wdata,
   output logic [sv39ptm_pkg::ENTRY_W-1:0]   rdata,
   output logic                              clear_busy
);

   localparam int AW    = $clog2(POOL_PAGES) + sv39ptm_pkg::SLOT_W;
   localparam int DEPTH = POOL_PAGES * sv39ptm_pkg::ENTRIES_PER_TABLE;

   logic [sv39ptm_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [sv39ptm_pkg::ENTRY_W-1:0] rdata_ff;
   logic [AW-1:0]                   clr_ptr_ff, clr_ptr_in;
   logic                            clr_busy_ff, clr_busy_in;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [sv39ptm_pkg::ENTRY_W-1:0] mem_wdata;

   always_comb begin
      clr_ptr_in  = clr_ptr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      mem_we    = clr_busy_ff | wr_en;
      mem_waddr = clr_busy_ff ? clr_ptr_ff : addr;
      mem_wdata = clr_busy_ff ? '0 : wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_ptr_ff  <= clr_ptr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata      = rdata_ff;
   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

>>> sv/sv39ptm_walker.sv
// Sequencer that walks levels two and one for each page, allocates pool
// pages, writes mapped leaves, gives one result per page. Depends on sv39ptm_pkg.
`default_nettype none

module sv39ptm_walker #(
   parameter int POOL_PAGES = sv39ptm_pkg::POOL_PAGES_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire [sv39ptm_pkg::VPN_W-1:0]           req_first_virtual_page,
   input  wire [sv39ptm_pkg::PPN_W-1:0]           req_first_physical_page,
   input  wire [sv39ptm_pkg::COUNT_W-1:0]         req_page_count,
   input  wire [sv39ptm_pkg::PERM_W-1:0]          req_permission_bits,
   input  wire [sv39ptm_pkg::PPN_W-1:0]           pool_base_ppn,
   input  wire                                    tbl_clear_busy,
   output logic                                   tbl_we,
   output logic [$clog2(POOL_PAGES)+sv39ptm_pkg::SLOT_W-1:0] tbl_addr,
   output logic [sv39ptm_pkg::ENTRY_W-1:0]        tbl_wdata,
   input  wire [sv39ptm_pkg::ENTRY_W-1:0]         tbl_rdata,
   output sv39ptm_pkg::alu_req_type               alu_req,
   input  sv39ptm_pkg::alu_rsp_type               alu_rsp,
   output logic                                   rsp_strobe,
   output logic [sv39ptm_pkg::ENTRY_W-1:0]        rsp_leaf_entry,
   output logic [sv39ptm_pkg::LOC_W-1:0]          rsp_entry_location,
   output logic [sv39ptm_pkg::USE_W-1:0]          rsp_pages_in_use,
   output logic [sv39ptm_pkg::STATUS_W-1:0]       rsp_map_status,
   output logic                                   rsp_last_of_range
);

   localparam int PW      = $clog2(POOL_PAGES);
   localparam int AW      = PW + sv39ptm_pkg::SLOT_W;
   localparam int CW      = $clog2(POOL_PAGES + 1);
   localparam int SW      = sv39ptm_pkg::SLOT_W;
   localparam int LOC_EXT = (AW > sv39ptm_pkg::LOC_W) ? AW : sv39ptm_pkg::LOC_W;
   localparam int USE_EXT = (CW > sv39ptm_pkg::USE_W) ? CW : sv39ptm_pkg::USE_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADDR  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_STEP  = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic                                lvl1_ff, lvl1_in;
   logic [PW-1:0]                       cur_ff, cur_in;
   logic [AW-1:0]                       addr_ff, addr_in;
   logic [sv39ptm_pkg::VPN_W-1:0]       vpn_ff, vpn_in;
   logic [sv39ptm_pkg::PPN_W-1:0]       ppn_ff, ppn_in;
   logic [sv39ptm_pkg::PERM_W-1:0]      perm_ff, perm_in;
   logic [sv39ptm_pkg::COUNT_W-1:0]     rem_ff, rem_in;
   logic [sv39ptm_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [CW-1:0]                       next_free_ff, next_free_in;

   logic                                rsp_strobe_ff, rsp_strobe_in;
   logic [sv39ptm_pkg::ENTRY_W-1:0]     rsp_leaf_ff, rsp_leaf_in;
   logic [sv39ptm_pkg::LOC_W-1:0]       rsp_loc_ff, rsp_loc_in;
   logic [sv39ptm_pkg::USE_W-1:0]       rsp_use_ff, rsp_use_in;
   logic [sv39ptm_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic [sv39ptm_pkg::COUNT_W-1:0]     count_clamped;
   logic [sv39ptm_pkg::ENTRY_W-1:0]     leaf;
   logic [sv39ptm_pkg::ENTRY_W-1:0]     pointer;
   logic [PW-1:0]                       new_page;
   logic                                pool_full;
   logic [LOC_EXT-1:0]                  loc_ext;
   logic [USE_EXT-1:0]                  use_ext;

   assign busy = (state_ff != S_IDLE) | tbl_clear_busy;

   assign leaf    = {10'd0, ppn_ff, 2'b00, perm_ff | 8'h01};
   assign pointer = {10'd0, alu_rsp.sum, 9'd0, 1'b1};
   assign pool_full = (next_free_ff >= CW'(POOL_PAGES));
   assign loc_ext   = LOC_EXT'(addr_ff);
   assign use_ext   = USE_EXT'(next_free_ff);

   always_comb begin
      if (req_page_count > sv39ptm_pkg::COUNT_W'(sv39ptm_pkg::MAX_RANGE_PAGES)) begin
         count_clamped = sv39ptm_pkg::COUNT_W'(sv39ptm_pkg::MAX_RANGE_PAGES);
      end else begin
         count_clamped = req_page_count;
      end
   end

   always_comb begin
      state_in      = state_ff;
      lvl1_in       = lvl1_ff;
      cur_in        = cur_ff;
      addr_in       = addr_ff;
      vpn_in        = vpn_ff;
      ppn_in        = ppn_ff;
      perm_in       = perm_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      next_free_in  = next_free_ff;
      rsp_strobe_in = 1'b0;
      rsp_leaf_in   = rsp_leaf_ff;
      rsp_loc_in    = rsp_loc_ff;
      rsp_use_in    = rsp_use_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      tbl_we        = 1'b0;
      tbl_wdata     = leaf;
      new_page      = '0;
      alu_req.op    = sv39ptm_pkg::ALU_ADD;
      alu_req.a     = '0;
      alu_req.b     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start && !tbl_clear_busy) begin
               vpn_in    = req_first_virtual_page;
               ppn_in    = req_first_physical_page;
               perm_in   = req_permission_bits;
               rem_in    = count_clamped;
               status_in = sv39ptm_pkg::ST_MAPPED;
               lvl1_in   = 1'b0;
               cur_in    = '0;
               if (count_clamped != '0) begin
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            if (lvl1_ff) begin
               addr_in = {cur_ff, vpn_ff[2*SW-1:SW]};
            end else begin
               addr_in = {cur_ff, vpn_ff[3*SW-1:2*SW]};
            end
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (tbl_rdata[0]) begin
               alu_req.op = sv39ptm_pkg::ALU_SUB;
               alu_req.a  = tbl_rdata[sv39ptm_pkg::PPN_LSB +: sv39ptm_pkg::PPN_W];
               alu_req.b  = pool_base_ppn;
               new_page   = alu_rsp.sum[PW-1:0];
               if (alu_rsp.beyond_pool) begin
                  status_in = sv39ptm_pkg::ST_OUTSIDE;
               end
            end else begin
               alu_req.a = pool_base_ppn;
               alu_req.b = sv39ptm_pkg::PPN_W'(next_free_ff);
               new_page  = next_free_ff[PW-1:0];
               if (pool_full) begin
                  status_in = sv39ptm_pkg::ST_EXHAUSTED;
               end else begin
                  tbl_we       = 1'b1;
                  tbl_wdata    = pointer;
                  next_free_in = next_free_ff + 1'b1;
               end
            end
            if ((tbl_rdata[0] && alu_rsp.beyond_pool) || (!tbl_rdata[0] && pool_full)) begin
               state_in = S_EMIT;
            end else if (!lvl1_ff) begin
               cur_in   = new_page;
               lvl1_in  = 1'b1;
               state_in = S_ADDR;
            end else begin
               cur_in   = new_page;
               addr_in  = {new_page, vpn_ff[SW-1:0]};
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            tbl_we        = (status_ff == sv39ptm_pkg::ST_MAPPED);
            tbl_wdata     = leaf;
            alu_req.a     = ppn_ff;
            alu_req.b     = sv39ptm_pkg::PPN_W'(1);
            ppn_in        = alu_rsp.sum;
            rsp_strobe_in = 1'b1;
            rsp_leaf_in   = leaf;
            rsp_loc_in    = (status_ff == sv39ptm_pkg::ST_MAPPED) ?
                            loc_ext[sv39ptm_pkg::LOC_W-1:0] : '0;
            rsp_use_in    = use_ext[sv39ptm_pkg::USE_W-1:0];
            rsp_status_in = status_ff;
            rsp_last_in   = (rem_ff == sv39ptm_pkg::COUNT_W'(1));
            rem_in        = rem_ff - 1'b1;
            state_in      = (rem_ff == sv39ptm_pkg::COUNT_W'(1)) ? S_IDLE : S_STEP;
         end
         S_STEP: begin
            alu_req.a = sv39ptm_pkg::PPN_W'(vpn_ff);
            alu_req.b = sv39ptm_pkg::PPN_W'(1);
            vpn_in    = alu_rsp.sum[sv39ptm_pkg::VPN_W-1:0];
            status_in = sv39ptm_pkg::ST_MAPPED;
            lvl1_in   = 1'b0;
            cur_in    = '0;
            state_in  = S_ADDR;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_free_ff  <= CW'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl1_ff       <= lvl1_in;
      cur_ff        <= cur_in;
      addr_ff       <= addr_in;
      vpn_ff        <= vpn_in;
      ppn_ff        <= ppn_in;
      perm_ff       <= perm_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      rsp_leaf_ff   <= rsp_leaf_in;
      rsp_loc_ff    <= rsp_loc_in;
      rsp_use_ff    <= rsp_use_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign tbl_addr           = addr_ff;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_leaf_entry     = rsp_leaf_ff;
   assign rsp_entry_location = rsp_loc_ff;
   assign rsp_pages_in_use   = rsp_use_ff;
   assign rsp_map_status     = rsp_status_ff;
   assign rsp_last_of_range  = rsp_last_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= CW'(POOL_PAGES))
      else $error("allocation counter ran past the pool");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_EMIT))
      else $error("result strobe without an emit cycle");

   a_skip_loc: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != sv39ptm_pkg::ST_MAPPED) |-> (rsp_loc_ff == '0))
      else $error("skipped page reports a location");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && tbl_we) |=> (next_free_ff == CW'($past(next_free_ff) + 1'b1)))
      else $error("pointer written without a page allocated");

   a_no_walk_clear: assert property (@(posedge clock) disable iff (reset)
      tbl_clear_busy |-> (state_ff == S_IDLE))
      else $error("walk running during the clearing pass");

endmodule

`default_nettype wire

>>> sv/sv39_page_table_mapper_top.sv
// Top level of the Sv39 page table mapper: configuration register and the
// walker, shared unit and table store. Depends on sv39ptm_pkg and the sv39ptm modules.
//
//   channel   ports                        handshake
//   request   start, busy, req_*           taken when start is high and busy is low
//   result    rsp_strobe, rsp_*            one cycle per result, cannot be held off
//   config    psel, penable, pwrite, ...   APB write in setup and access cycles
//
// After reset a clearing pass zeroes all POOL_PAGES * 512 table store entries
// (32768 by default), during which busy stays high.
// A request keeps busy high from acceptance until its last page is emitted. When
// every page is mapped, each page takes two table reads (address, fetch and check
// states each), an emit state and a step state, with no step after the last page.
// A page skipped at level two ends its walk early, without the level-one read.
// A request of zero pages is taken and gives no result.
`default_nettype none

module sv39_page_table_mapper_top #(
   parameter int POOL_PAGES = sv39ptm_pkg::POOL_PAGES_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire [sv39ptm_pkg::VPN_W-1:0]          req_first_virtual_page,
   input  wire [sv39ptm_pkg::PPN_W-1:0]          req_first_physical_page,
   input  wire [sv39ptm_pkg::COUNT_W-1:0]        req_page_count,
   input  wire [sv39ptm_pkg::PERM_W-1:0]         req_permission_bits,
   output logic                                  rsp_strobe,
   output logic [sv39ptm_pkg::ENTRY_W-1:0]       rsp_leaf_entry,
   output logic [sv39ptm_pkg::LOC_W-1:0]         rsp_entry_location,
   output logic [sv39ptm_pkg::USE_W-1:0]         rsp_pages_in_use,
   output logic [sv39ptm_pkg::STATUS_W-1:0]      rsp_map_status,
   output logic                                  rsp_last_of_range,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire [2:0]                             paddr,
   input  wire [63:0]                            pwdata,
   output logic [63:0]                           prdata,
   output logic                                  pready
);

   localparam int AW = $clog2(POOL_PAGES) + sv39ptm_pkg::SLOT_W;

   logic [sv39ptm_pkg::PPN_W-1:0]   pool_base_ff, pool_base_in;
   logic                            pool_base_wr;
   logic                            tbl_clear_busy;
   logic                            tbl_we;
   logic [AW-1:0]                   tbl_addr;
   logic [sv39ptm_pkg::ENTRY_W-1:0] tbl_wdata;
   logic [sv39ptm_pkg::ENTRY_W-1:0] tbl_rdata;
   sv39ptm_pkg::alu_req_type        alu_req;
   sv39ptm_pkg::alu_rsp_type        alu_rsp;

   // The only register spans the whole 8-byte window, so every offset selects it.
   assign pool_base_wr = psel & penable & pwrite & (paddr[2:0] <= 3'd7);

   always_comb begin
      pool_base_in = pool_base_ff;
      if (pool_base_wr) begin
         pool_base_in = pwdata[sv39ptm_pkg::PPN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= sv39ptm_pkg::POOL_BASE_RESET;
      end else begin
         pool_base_ff <= pool_base_in;
      end
   end

   assign prdata = {20'd0, pool_base_ff};
   assign pready = 1'b1;

   sv39ptm_alu #(
      .POOL_PAGES (POOL_PAGES)
   ) u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   sv39ptm_table #(
      .POOL_PAGES (POOL_PAGES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (tbl_we),
      .addr       (tbl_addr),
      .wdata      (tbl_wdata),
      .rdata      (tbl_rdata),
      .clear_busy (tbl_clear_busy)
   );

   sv39ptm_walker #(
      .POOL_PAGES (POOL_PAGES)
   ) u_walker (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_first_virtual_page  (req_first_virtual_page),
      .req_first_physical_page (req_first_physical_page),
      .req_page_count          (req_page_count),
      .req_permission_bits     (req_permission_bits),
      .pool_base_ppn           (pool_base_ff),
      .tbl_clear_busy          (tbl_clear_busy),
      .tbl_we                  (tbl_we),
      .tbl_addr                (tbl_addr),
      .tbl_wdata               (tbl_wdata),
      .tbl_rdata               (tbl_rdata),
      .alu_req                 (alu_req),
      .alu_rsp                 (alu_rsp),
      .rsp_strobe              (rsp_strobe),
      .rsp_leaf_entry          (rsp_leaf_entry),
      .rsp_entry_location      (rsp_entry_location),
      .rsp_pages_in_use        (rsp_pages_in_use),
      .rsp_map_status          (rsp_map_status),
      .rsp_last_of_range       (rsp_last_of_range)
   );

endmodule

`default_nettype wire
